[src/b32e_pkg.sv]
`default_nettype none

package b32e_pkg;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int SYM_W    = 8;
  localparam int CH_W     = 8;
  localparam int STATUS_W = 3;
  localparam int POLY_W   = 30;
  localparam int VCNT_W   = 10;
  localparam int LEN_W    = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  // prefix store
  localparam int MAX_PREFIX = 128;
  localparam int PADDR_W    = $clog2(MAX_PREFIX);
  localparam int PCNT_W     = $clog2(MAX_PREFIX + 1);

  // item function codes
  localparam logic [FUNC_W-1:0] F_PREFIX = 2'd0;
  localparam logic [FUNC_W-1:0] F_DATA   = 2'd1;
  localparam logic [FUNC_W-1:0] F_END    = 2'd2;

  // string phase codes
  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_ERROR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_CHAR = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ORDER    = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'd1;

  localparam logic [VCNT_W-1:0] MAX_LEN_RESET = 10'd90;

  // output character source
  localparam logic [2:0] OSEL_ERR  = 3'd0;
  localparam logic [2:0] OSEL_SYM  = 3'd1;
  localparam logic [2:0] OSEL_SEP  = 3'd2;
  localparam logic [2:0] OSEL_DATA = 3'd3;
  localparam logic [2:0] OSEL_CHK  = 3'd4;

  // prefix character limits, data value limit and separator character
  localparam logic [SYM_W-1:0] CH_LOW      = 8'd33;
  localparam logic [SYM_W-1:0] CH_HIGH     = 8'd126;
  localparam logic [SYM_W-1:0] CH_UPPER_LO = 8'd65;
  localparam logic [SYM_W-1:0] CH_UPPER_HI = 8'd90;
  localparam logic [SYM_W-1:0] DATA_MAX    = 8'd31;
  localparam logic [CH_W-1:0]  CH_SEP      = 8'h31;

  // extra length counted on top of prefix and values
  localparam logic [LEN_W-1:0] LEN_EXTRA_ITEM = 12'd8;
  localparam logic [LEN_W-1:0] LEN_EXTRA_END  = 12'd7;

  // polymod generator and final constants
  localparam logic [POLY_W-1:0] GEN0 = 30'h3b6a57b2;
  localparam logic [POLY_W-1:0] GEN1 = 30'h26508e6d;
  localparam logic [POLY_W-1:0] GEN2 = 30'h1ea119fa;
  localparam logic [POLY_W-1:0] GEN3 = 30'h3d4233dd;
  localparam logic [POLY_W-1:0] GEN4 = 30'h2a1462b3;
  localparam logic [POLY_W-1:0] POLY_INIT  = 30'd1;
  localparam logic [POLY_W-1:0] FINAL_B32  = 30'd1;
  localparam logic [POLY_W-1:0] FINAL_B32M = 30'h2bc830a3;

  localparam logic [8*32-1:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  typedef struct packed {
    logic       load_item;
    logic       store_pfx;
    logic       step_zero;
    logic       walk_start;
    logic       rd_issue;
    logic       walk_fold;
    logic       data_fold;
    logic       set_data;
    logic       xor_final;
    logic       shift_out;
    logic       clear_str;
    logic       set_err;
    logic       out_load;
    logic [2:0] out_sel;
    logic       out_last;
  } b32e_cmd_t;

  typedef struct packed {
    logic [1:0]          phase;
    logic [FUNC_W-1:0]   func;
    logic [STATUS_W-1:0] item_err;
    logic                walk_done;
    logic                out_free;
  } b32e_stat_t;

  function automatic logic [POLY_W-1:0] pm_step(input logic [POLY_W-1:0] v);
    logic [4:0]        top;
    logic [POLY_W-1:0] r;
    top = v[POLY_W-1:POLY_W-5];
    r = {v[POLY_W-6:0], 5'b00000};
    if (top[0]) r = r ^ GEN0;
    if (top[1]) r = r ^ GEN1;
    if (top[2]) r = r ^ GEN2;
    if (top[3]) r = r ^ GEN3;
    if (top[4]) r = r ^ GEN4;
    return r;
  endfunction

  // first character sits in the top byte of the string
  function automatic logic [CH_W-1:0] charset_lookup(input logic [4:0] v);
    logic [7:0] idx;
    idx = {~v, 3'b000};
    return CHARSET[idx +: 8];
  endfunction

endpackage

`default_nettype wire

[src/b32e_in_if.sv]
`default_nettype none

interface b32e_in_if;
  logic                           valid;
  logic                           ready;
  logic [b32e_pkg::FUNC_W-1:0]    func;
  logic [b32e_pkg::SYM_W-1:0]     sym;

  modport source (output valid, output func, output sym, input ready);
  modport sink   (input valid, input func, input sym, output ready);
endinterface

`default_nettype wire

[src/b32e_out_if.sv]
`default_nettype none

interface b32e_out_if;
  logic                             valid;
  logic                             ready;
  logic [b32e_pkg::CH_W-1:0]        ch;
  logic [b32e_pkg::STATUS_W-1:0]    status;
  logic                             last;

  modport source (output valid, output ch, output status, output last, input ready);
  modport sink   (input valid, input ch, input status, input last, output ready);
endinterface

`default_nettype wire

[src/bech32_checksum_encoder.sv]
`default_nettype none

// bech32 / bech32m string encoder. a string arrives as prefix words, then 5-bit
// data words, then one end word; characters leave one per word on out_word,
// with last set on the sixth checksum character or on an error word (status
// non-zero, ch zero). after an error every word is dropped until the end word,
// which restarts the string silently. one word is in flight at a time: a prefix
// or data word is accepted, checked and emitted; the first data word (or an end
// word with no data) also steps zero, walks the prefix store through its single
// registered read port and emits the separator; an end word runs six zero steps
// of the shared polymod unit, then six checksum characters. the user must write
// configuration (index 0 variant, index 1 length limit) through cfg_we, cfg_idx
// and cfg_wdata while the encoder is idle; the block does not enforce it.

module bech32_checksum_encoder (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  b32e_in_if.sink                                  in_word,
  b32e_out_if.source                               out_word,
  input  wire logic                                cfg_we,
  input  wire logic [b32e_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [b32e_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  b32e_pkg::b32e_cmd_t  cmd;
  b32e_pkg::b32e_stat_t stat;
  logic                 in_ready;

  // sequencer: accepts a word, checks it, drives the walk and emit steps
  b32e_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // polymod, counters, prefix store, config and the result register
  b32e_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_func    (in_word.func),
    .in_sym     (in_word.sym),
    .out_valid  (out_word.valid),
    .out_ready  (out_word.ready),
    .out_ch     (out_word.ch),
    .out_status (out_word.status),
    .out_last   (out_word.last),
    .cmd        (cmd),
    .stat       (stat)
  );

  assign in_word.ready = in_ready;

endmodule

`default_nettype wire

[src/b32e_ctrl.sv]
`default_nettype none

module b32e_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire b32e_pkg::b32e_stat_t  stat,
  output b32e_pkg::b32e_cmd_t        cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ERR,
    S_PFX,
    S_WALK_Z,
    S_WALK_RD,
    S_WALK_FOLD,
    S_SEP,
    S_DATA,
    S_FIN,
    S_XOR,
    S_CHK
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.out_sel = b32e_pkg::OSEL_ERR;
    in_ready  = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.phase == b32e_pkg::PH_ERROR) begin
          // swallow items until the end word restarts the string
          cmd.clear_str = (stat.func == b32e_pkg::F_END);
          state_nxt     = S_IDLE;
        end else if (stat.item_err != b32e_pkg::ST_OK) begin
          state_nxt = S_ERR;
        end else if (stat.func == b32e_pkg::F_PREFIX) begin
          state_nxt = S_PFX;
        end else if (stat.phase == b32e_pkg::PH_PREFIX) begin
          state_nxt = S_WALK_Z;
        end else if (stat.func == b32e_pkg::F_DATA) begin
          state_nxt = S_DATA;
        end else begin
          cnt_nxt   = 3'd0;
          state_nxt = S_FIN;
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = b32e_pkg::OSEL_ERR;
          cmd.out_last = 1'b1;
          cmd.set_err  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_PFX: begin
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = b32e_pkg::OSEL_SYM;
          cmd.store_pfx = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_WALK_Z: begin
        cmd.step_zero  = 1'b1;
        cmd.walk_start = 1'b1;
        state_nxt      = S_WALK_RD;
      end
      S_WALK_RD: begin
        if (stat.walk_done) begin
          state_nxt = S_SEP;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_WALK_FOLD;
        end
      end
      S_WALK_FOLD: begin
        cmd.walk_fold = 1'b1;
        state_nxt     = S_WALK_RD;
      end
      S_SEP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = b32e_pkg::OSEL_SEP;
          cmd.set_data = 1'b1;
          cnt_nxt      = 3'd0;
          state_nxt    = (stat.func == b32e_pkg::F_DATA) ? S_DATA : S_FIN;
        end
      end
      S_DATA: begin
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = b32e_pkg::OSEL_DATA;
          cmd.data_fold = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FIN: begin
        // six zero steps before the final constant
        cmd.step_zero = 1'b1;
        cnt_nxt       = cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          state_nxt = S_XOR;
        end
      end
      S_XOR: begin
        cmd.xor_final = 1'b1;
        cnt_nxt       = 3'd0;
        state_nxt     = S_CHK;
      end
      S_CHK: begin
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = b32e_pkg::OSEL_CHK;
          cmd.out_last  = (cnt_r == 3'd5);
          cmd.shift_out = 1'b1;
          cnt_nxt       = cnt_r + 3'd1;
          if (cnt_r == 3'd5) begin
            cmd.clear_str = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[src/b32e_dp.sv]
`default_nettype none

module b32e_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [b32e_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [b32e_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic [b32e_pkg::FUNC_W-1:0]         in_func,
  input  wire logic [b32e_pkg::SYM_W-1:0]          in_sym,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [b32e_pkg::CH_W-1:0]                out_ch,
  output logic [b32e_pkg::STATUS_W-1:0]            out_status,
  output logic                                     out_last,
  input  wire b32e_pkg::b32e_cmd_t                 cmd,
  output b32e_pkg::b32e_stat_t                     stat
);

  localparam int PW = b32e_pkg::PCNT_W;
  localparam int AW = b32e_pkg::PADDR_W;
  localparam int YW = b32e_pkg::POLY_W;
  localparam int VW = b32e_pkg::VCNT_W;
  localparam int LW = b32e_pkg::LEN_W;

  // configuration
  logic          variant_r;
  logic [VW-1:0] max_len_r;

  // per string state
  logic [1:0]    phase_r, phase_nxt;
  logic [PW-1:0] pcnt_r, pcnt_nxt;
  logic [VW-1:0] vcnt_r, vcnt_nxt;
  logic [YW-1:0] poly_r, poly_nxt;
  logic [PW-1:0] walk_idx_r, walk_idx_nxt;

  // current item
  logic [b32e_pkg::FUNC_W-1:0] func_r;
  logic [b32e_pkg::SYM_W-1:0]  sym_r;

  // prefix store
  logic [b32e_pkg::SYM_W-1:0] pfx_mem [b32e_pkg::MAX_PREFIX];
  logic [b32e_pkg::SYM_W-1:0] rdata_r;

  // result register
  logic                          out_valid_r;
  logic [b32e_pkg::CH_W-1:0]     ch_r;
  logic [b32e_pkg::STATUS_W-1:0] status_r;
  logic                          last_r;

  logic [LW-1:0]                 len_base;
  logic                          long_item, long_end, bad_char;
  logic [b32e_pkg::STATUS_W-1:0] item_err;
  logic [YW-1:0]                 poly_step;
  logic [b32e_pkg::CH_W-1:0]     ch_sel;

  // length so far, checked against the limit per item
  assign len_base  = LW'(pcnt_r) + LW'(vcnt_r);
  assign long_item = (len_base + b32e_pkg::LEN_EXTRA_ITEM) > LW'(max_len_r);
  assign long_end  = (len_base + b32e_pkg::LEN_EXTRA_END) > LW'(max_len_r);
  assign bad_char  = (sym_r < b32e_pkg::CH_LOW) || (sym_r > b32e_pkg::CH_HIGH) ||
                     ((sym_r >= b32e_pkg::CH_UPPER_LO) && (sym_r <= b32e_pkg::CH_UPPER_HI));

  always_comb begin
    case (func_r)
      b32e_pkg::F_PREFIX: begin
        if (phase_r != b32e_pkg::PH_PREFIX)          item_err = b32e_pkg::ST_ORDER;
        else if (bad_char)                           item_err = b32e_pkg::ST_BAD_CHAR;
        else if (pcnt_r >= PW'(b32e_pkg::MAX_PREFIX)) item_err = b32e_pkg::ST_ORDER;
        else if (long_item)                          item_err = b32e_pkg::ST_TOO_LONG;
        else                                         item_err = b32e_pkg::ST_OK;
      end
      b32e_pkg::F_DATA: begin
        if (long_item)                        item_err = b32e_pkg::ST_TOO_LONG;
        else if (sym_r > b32e_pkg::DATA_MAX)  item_err = b32e_pkg::ST_TOO_BIG;
        else                                  item_err = b32e_pkg::ST_OK;
      end
      b32e_pkg::F_END: begin
        item_err = long_end ? b32e_pkg::ST_TOO_LONG : b32e_pkg::ST_OK;
      end
      default: begin
        item_err = b32e_pkg::ST_ORDER;
      end
    endcase
  end

  assign poly_step = b32e_pkg::pm_step(poly_r);

  always_comb begin
    phase_nxt    = phase_r;
    pcnt_nxt     = pcnt_r;
    vcnt_nxt     = vcnt_r;
    poly_nxt     = poly_r;
    walk_idx_nxt = walk_idx_r;

    if (cmd.store_pfx) begin
      pcnt_nxt = pcnt_r + PW'(1);
      poly_nxt = poly_step ^ YW'(sym_r[7:5]);
    end
    if (cmd.step_zero) begin
      poly_nxt = poly_step;
    end
    if (cmd.walk_start) begin
      walk_idx_nxt = '0;
    end
    if (cmd.rd_issue) begin
      walk_idx_nxt = walk_idx_r + PW'(1);
    end
    if (cmd.walk_fold) begin
      poly_nxt = poly_step ^ YW'(rdata_r[4:0]);
    end
    if (cmd.set_data) begin
      phase_nxt = b32e_pkg::PH_DATA;
    end
    if (cmd.data_fold) begin
      poly_nxt = poly_step ^ YW'(sym_r[4:0]);
      vcnt_nxt = vcnt_r + VW'(1);
    end
    if (cmd.xor_final) begin
      poly_nxt = poly_r ^ (variant_r ? b32e_pkg::FINAL_B32M : b32e_pkg::FINAL_B32);
    end
    if (cmd.shift_out) begin
      poly_nxt = {poly_r[YW-6:0], 5'b00000};
    end
    if (cmd.set_err) begin
      phase_nxt = b32e_pkg::PH_ERROR;
    end
    if (cmd.clear_str) begin
      phase_nxt = b32e_pkg::PH_PREFIX;
      pcnt_nxt  = '0;
      vcnt_nxt  = '0;
      poly_nxt  = b32e_pkg::POLY_INIT;
    end
  end

  always_comb begin
    case (cmd.out_sel)
      b32e_pkg::OSEL_SYM:  ch_sel = sym_r;
      b32e_pkg::OSEL_SEP:  ch_sel = b32e_pkg::CH_SEP;
      b32e_pkg::OSEL_DATA: ch_sel = b32e_pkg::charset_lookup(sym_r[4:0]);
      b32e_pkg::OSEL_CHK:  ch_sel = b32e_pkg::charset_lookup(poly_r[YW-1:YW-5]);
      default:             ch_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r   <= 1'b0;
      max_len_r   <= b32e_pkg::MAX_LEN_RESET;
      phase_r     <= b32e_pkg::PH_PREFIX;
      pcnt_r      <= '0;
      vcnt_r      <= '0;
      poly_r      <= b32e_pkg::POLY_INIT;
      walk_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_idx == b32e_pkg::CFG_VARIANT)) begin
        variant_r <= cfg_wdata[0];
      end
      if (cfg_we && (cfg_idx == b32e_pkg::CFG_MAX_LEN)) begin
        max_len_r <= cfg_wdata;
      end
      phase_r    <= phase_nxt;
      pcnt_r     <= pcnt_nxt;
      vcnt_r     <= vcnt_nxt;
      poly_r     <= poly_nxt;
      walk_idx_r <= walk_idx_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r <= in_func;
      sym_r  <= in_sym;
    end
    if (cmd.out_load) begin
      ch_r     <= ch_sel;
      status_r <= (cmd.out_sel == b32e_pkg::OSEL_ERR) ? item_err : b32e_pkg::ST_OK;
      last_r   <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_pfx) begin
      pfx_mem[pcnt_r[AW-1:0]] <= sym_r;
    end
    if (cmd.rd_issue) begin
      rdata_r <= pfx_mem[walk_idx_r[AW-1:0]];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_ch     = ch_r;
  assign out_status = status_r;
  assign out_last   = last_r;

  assign stat.phase     = phase_r;
  assign stat.func      = func_r;
  assign stat.item_err  = item_err;
  assign stat.walk_done = (walk_idx_r == pcnt_r);
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

`default_nettype wire

[src/b32e_checker.sv]
`default_nettype none

module b32e_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [b32e_pkg::CH_W-1:0]           out_ch,
  input wire logic [b32e_pkg::STATUS_W-1:0]       out_status,
  input wire logic                                out_last
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ch) &&
    $stable(out_status) && $stable(out_last))
    else $error("result word changed while stalled");

  // error words close the string and carry no character
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != b32e_pkg::ST_OK) |-> out_last && (out_ch == '0))
    else $error("error word without last or with a character");

  // one word in flight: no accept on the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind bech32_checksum_encoder b32e_checker u_b32e_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_word.valid),
  .in_ready   (in_word.ready),
  .out_valid  (out_word.valid),
  .out_ready  (out_word.ready),
  .out_ch     (out_word.ch),
  .out_status (out_word.status),
  .out_last   (out_word.last)
);

`default_nettype wire

[tb/b32e_stream_checker.sv]
`timescale 1ns / 100ps

// watches both channels and the register port, predicts the character stream
module b32e_stream_checker
  import b32e_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  b32e_in_if                         in_mon,
  b32e_out_if                        out_mon,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         outstanding,
  output int                         chars_checked
);

  typedef enum logic [1:0] {STR_PREFIX, STR_DATA, STR_ABORTED} str_state_t;

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [STATUS_W-1:0] status;
    logic                last;
  } enc_char_t;

  localparam logic [POLY_W-1:0] GEN_TAB [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  string               cs_alphabet = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
  str_state_t          str_state;
  logic                variant_m;
  logic [CFG_DATA_W-1:0] len_limit;
  logic [SYM_W-1:0]    hrp_mem [MAX_PREFIX];
  int                  hrp_len;
  int                  val_len;
  logic [POLY_W-1:0]   chk_acc;
  enc_char_t           pending_chars [$];
  int                  err_n;
  int                  seen_n;

  function automatic logic [POLY_W-1:0] polymod_shift(input logic [POLY_W-1:0] v);
    logic [POLY_W-1:0] r;
    r = v << 5;
    for (int b = 0; b < 5; b++)
      if (v[POLY_W-5+b]) r = r ^ GEN_TAB[b];
    return r;
  endfunction

  function automatic void emit(input logic [CH_W-1:0] ch, input logic [STATUS_W-1:0] st,
                               input logic last);
    pending_chars.push_back('{ch, st, last});
  endfunction

  function automatic void restart_string();
    str_state = STR_PREFIX;
    hrp_len   = 0;
    val_len   = 0;
    chk_acc   = 30'd1;
  endfunction

  function automatic void abort_string(input logic [STATUS_W-1:0] st);
    str_state = STR_ABORTED;
    emit(8'd0, st, 1'b1);
  endfunction

  // zero step, low bits of every stored prefix char, then the separator
  function automatic void walk_prefix();
    chk_acc = polymod_shift(chk_acc);
    for (int i = 0; i < hrp_len; i++)
      chk_acc = polymod_shift(chk_acc) ^ {25'd0, hrp_mem[i][4:0]};
    emit("1", ST_OK, 1'b0);
    str_state = STR_DATA;
  endfunction

  function automatic void finish_checksum();
    logic [POLY_W-1:0] c;
    c = chk_acc;
    repeat (6) c = polymod_shift(c);
    c = c ^ (variant_m ? 30'h2bc830a3 : 30'd1);
    for (int i = 0; i < 6; i++)
      emit(cs_alphabet[c[(5-i)*5 +: 5]], ST_OK, i == 5);
    restart_string();
  endfunction

  function automatic void encode_word(input logic [FUNC_W-1:0] func,
                                      input logic [SYM_W-1:0] sym);
    if (str_state == STR_ABORTED) begin
      if (func == F_END) restart_string();
      return;
    end
    case (func)
      F_PREFIX: begin
        if (str_state != STR_PREFIX) abort_string(ST_ORDER);
        else if (sym < 8'd33 || sym > 8'd126 || (sym >= "A" && sym <= "Z"))
          abort_string(ST_BAD_CHAR);
        else if (hrp_len >= MAX_PREFIX) abort_string(ST_ORDER);
        else if (hrp_len + val_len + 8 > len_limit) abort_string(ST_TOO_LONG);
        else begin
          hrp_mem[hrp_len] = sym;
          hrp_len++;
          chk_acc = polymod_shift(chk_acc) ^ {27'd0, sym[7:5]};
          emit(sym, ST_OK, 1'b0);
        end
      end
      F_DATA: begin
        if (hrp_len + val_len + 8 > len_limit) abort_string(ST_TOO_LONG);
        else if (sym > 8'd31) abort_string(ST_TOO_BIG);
        else begin
          if (str_state == STR_PREFIX) walk_prefix();
          chk_acc = polymod_shift(chk_acc) ^ {25'd0, sym[4:0]};
          val_len++;
          emit(cs_alphabet[sym[4:0]], ST_OK, 1'b0);
        end
      end
      F_END: begin
        if (hrp_len + val_len + 7 > len_limit) abort_string(ST_TOO_LONG);
        else begin
          if (str_state == STR_PREFIX) walk_prefix();
          finish_checksum();
        end
      end
      default: abort_string(ST_ORDER);
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    enc_char_t got;
    enc_char_t want;
    if (!rst_n) begin
      variant_m = 1'b0;
      len_limit = 10'd90;
      restart_string();
      pending_chars.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.ch, out_mon.status, out_mon.last};
        if (pending_chars.size() == 0) begin
          err_n++;
          if (err_n <= 10)
            $display("%0t: unexpected char %h status %0d last %0b", $time,
                     got.ch, got.status, got.last);
        end else begin
          want = pending_chars.pop_front();
          seen_n++;
          if (got.ch !== want.ch || got.status !== want.status || got.last !== want.last) begin
            err_n++;
            if (err_n <= 10)
              $display("%0t: char %h status %0d last %0b, expected %h status %0d last %0b",
                       $time, got.ch, got.status, got.last, want.ch, want.status, want.last);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) encode_word(in_mon.func, in_mon.sym);
      if (cfg_we) begin
        if (cfg_idx == CFG_VARIANT) variant_m = cfg_wdata[0];
        else if (cfg_idx == CFG_MAX_LEN) len_limit = cfg_wdata;
      end
    end
    mismatches    <= err_n;
    outstanding   <= pending_chars.size();
    chars_checked <= seen_n;
  end

endmodule

[tb/tb_bech32_checksum_encoder.sv]
`timescale 1ns / 100ps

module tb_bech32_checksum_encoder;
  import b32e_pkg::*;

  localparam int LIMIT_CYCLES    = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  // longest silent stretch: covers an ignored word, which emits nothing
  localparam int SETTLE_CYCLES   = 40;
  localparam int PHASE_WORDS     = 18;

  // the block has no code for func 3, it must be reported as out of order
  localparam logic [FUNC_W-1:0] F_RESERVED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  b32e_in_if  in_word ();
  b32e_out_if out_word ();

  int mismatches;
  int outstanding;
  int chars_checked;

  // knobs shared by the sender and the receiver
  int idle_pct;
  int stall_pct;
  bit hold_req;
  int words_sent;
  int settings_used;

  bech32_checksum_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  b32e_stream_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_word),
    .out_mon       (out_word),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .chars_checked (chars_checked)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver: random back-pressure, plus one long hold-off on request so the
  // encoder fills up and has to stall its input side
  initial begin
    out_word.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_word.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_word.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on the whole run
  initial begin : watchdog
    int n;
    n = 0;
    while (n < LIMIT_CYCLES) begin
      @(posedge clk);
      n++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // offer one word, with random idle cycles first, and hold it until taken
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s);
    while ($urandom_range(99) < idle_pct) begin
      in_word.valid <= 1'b0;
      @(posedge clk);
    end
    in_word.valid <= 1'b1;
    in_word.func  <= f;
    in_word.sym   <= s;
    do @(posedge clk); while (!in_word.ready);
    words_sent++;
  endtask

  // mostly the intended word, now and then a random one to break the string
  task automatic send_mixed(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s);
    if ($urandom_range(24) == 0)
      send_word(FUNC_W'($urandom_range(3)), SYM_W'($urandom_range(255)));
    else
      send_word(f, s);
  endtask

  // wait for every predicted char, then let any silent word finish inside the block
  task automatic drain();
    in_word.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic variant, input logic [CFG_DATA_W-1:0] len);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_VARIANT;
    cfg_wdata <= CFG_DATA_W'(variant);
    @(posedge clk);
    cfg_idx   <= CFG_MAX_LEN;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // legal prefix char: 33..126 without upper case
  function automatic logic [SYM_W-1:0] hrp_char();
    int v;
    v = $urandom_range(100, 33);
    if (v >= 65) v += 26;
    return SYM_W'(v);
  endfunction

  // mostly well-formed string with random content, now and then without its end word
  task automatic send_string();
    int n_hrp;
    int n_val;
    n_hrp = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
    n_val = $urandom_range(12);
    repeat (n_hrp) send_mixed(F_PREFIX, hrp_char());
    repeat (n_val) send_mixed(F_DATA, SYM_W'($urandom_range(31)));
    if ($urandom_range(19) != 0) send_word(F_END, SYM_W'($urandom_range(255)));
  endtask

  initial begin : stimulus
    int start;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_VARIANT;
    cfg_wdata     <= '0;
    in_word.valid <= 1'b0;
    in_word.func  <= F_PREFIX;
    in_word.sym   <= '0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    words_sent    = 0;
    settings_used = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the reset settings: bech32, limit 90
    // prefix extremes, data extremes, full checksum
    send_word(F_PREFIX, 8'd33);
    send_word(F_PREFIX, 8'd126);
    send_word(F_DATA, 8'd0);
    send_word(F_DATA, 8'd31);
    send_word(F_END, 8'd0);
    // empty string: the end word walks an empty prefix
    send_word(F_END, 8'hff);
    // upper case char aborts, data after it is dropped, end restarts silently
    send_word(F_PREFIX, "z");
    send_word(F_PREFIX, "A");
    send_word(F_DATA, 8'd3);
    send_word(F_END, 8'd0);
    send_word(F_PREFIX, "Z");
    send_word(F_END, 8'd0);
    // just outside the printable range on both sides
    send_word(F_PREFIX, 8'd32);
    send_word(F_END, 8'd0);
    send_word(F_PREFIX, 8'd127);
    send_word(F_END, 8'd0);
    // value too big with no prefix
    send_word(F_DATA, 8'd32);
    send_word(F_END, 8'd0);
    // error on the first data word: no walk, no separator
    send_word(F_PREFIX, "q");
    send_word(F_DATA, 8'd255);
    send_word(F_END, 8'd0);
    // prefix char once the data phase has begun
    send_word(F_PREFIX, "b");
    send_word(F_DATA, 8'd1);
    send_word(F_PREFIX, "c");
    send_word(F_END, 8'd0);
    // undefined function code
    send_word(F_RESERVED, 8'd0);
    send_word(F_END, 8'd0);
    drain();

    for (int p = 0; p < 6; p++) begin
      start = words_sent;
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          set_config(1'b0, 10'd90);
        end
        1: begin
          // limit 135 fits exactly 128 prefix chars; the 129th overflows the
          // store, which wins over the length error it would also raise
          idle_pct  = 0;
          stall_pct = 0;
          set_config(1'b1, 10'd135);
          hold_req = 1'b1;
          repeat (MAX_PREFIX + 1) send_word(F_PREFIX, hrp_char());
          send_word(F_END, 8'd0);
        end
        2: begin
          idle_pct  = 61;
          stall_pct = 0;
          set_config(1'b0, 10'd8);
          // length error takes priority over value too big
          send_word(F_DATA, 8'd0);
          send_word(F_DATA, 8'd200);
          send_word(F_END, 8'd0);
          // bad char takes priority over length
          send_word(F_PREFIX, "a");
          send_word(F_PREFIX, "A");
          send_word(F_END, 8'd0);
          // exactly at the limit
          send_word(F_PREFIX, "a");
          send_word(F_END, 8'd0);
          // one over the limit on a data word
          send_word(F_PREFIX, "a");
          send_word(F_DATA, 8'd5);
          send_word(F_END, 8'd0);
        end
        3: begin
          idle_pct  = 0;
          stall_pct = 61;
          set_config(1'b1, CFG_DATA_W'($urandom_range(1023, 8)));
        end
        4: begin
          idle_pct  = 24;
          stall_pct = 24;
          set_config(1'b1, 10'd20);
        end
        default: begin
          idle_pct  = 0;
          stall_pct = 0;
          set_config(1'b0, 10'd1023);
        end
      endcase
      while (words_sent - start < PHASE_WORDS) send_string();
      drain();
    end

    $display("bech32 stream: %0d input words over %0d register settings, %0d chars compared",
             words_sent, settings_used, chars_checked);
    $display("both variants, limits 8 to 1023, prefix overflow and a long output hold-off");
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[bech32_checksum_encoder.f]
src/b32e_pkg.sv
src/b32e_in_if.sv
src/b32e_out_if.sv
src/b32e_ctrl.sv
src/b32e_dp.sv
src/bech32_checksum_encoder.sv
src/b32e_checker.sv
tb/b32e_stream_checker.sv
tb/tb_bech32_checksum_encoder.sv
